/* hdl/gled_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gled_pkg
// Shared types, sizes and helpers of the grid local extremum detector.
// ----------------------------------------------------------------------------
package gled_pkg;

  localparam int unsigned LineDepth   = 128;
  localparam int unsigned PixBits     = 16;
  localparam int unsigned ColBits     = $clog2(LineDepth);
  localparam int unsigned RowBits     = 12;
  localparam int unsigned MaxRows     = 4096;
  localparam int unsigned RowsRegBits = 13;
  localparam int unsigned ColsRegBits = 8;
  localparam int unsigned AddrBits    = 4;
  localparam int unsigned DataBits    = 32;

  typedef logic signed [PixBits-1:0] pix_t;

  typedef enum logic [1:0] {
    RegFrameRows    = 2'd0,
    RegFrameCols    = 2'd1,
    RegExtremumKind = 2'd2
  } reg_idx_e;

  // clamped frame geometry and mode
  typedef struct packed {
    logic [RowBits-1:0] last_row;
    logic [ColBits-1:0] last_col;
    logic               kind;
  } cfg_t;

  // pixel entering the decision stage with its position and border flags
  typedef struct packed {
    pix_t               pixel;
    logic [RowBits-1:0] row;
    logic [ColBits-1:0] col;
    logic               bank;
    logic               has_up;
    logic               has_up2;
    logic               has_left;
    logic               has_left2;
    logic               has_right;
    logic               last_row;
    logic               last_col;
  } item_t;

  // read data of both line stores, at column j and j+1
  typedef struct packed {
    pix_t a0;
    pix_t a1;
    pix_t b0;
    pix_t b1;
  } rd_t;

  typedef struct packed {
    logic [RowBits-1:0] row;
    logic [ColBits-1:0] col;
    pix_t               pix;
    logic               ext;
    logic               done;
  } res_t;

  // centre wins against neighbour in the selected sense
  function automatic logic beats(input logic kind, input pix_t centre, input pix_t nb);
    return kind ? (centre > nb) : (centre < nb);
  endfunction

endpackage

/* hdl/gled_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gled_if
// Valid/ready channels: pixel words in, decision words out.
// ----------------------------------------------------------------------------
interface gled_pix_if;
  logic           valid;
  logic           ready;
  gled_pkg::pix_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface gled_dec_if;
  logic                         valid;
  logic                         ready;
  logic [gled_pkg::RowBits-1:0] pixel_row;
  logic [gled_pkg::ColBits-1:0] pixel_col;
  gled_pkg::pix_t               pixel_out;
  logic                         is_extremum;
  logic                         frame_done;

  modport source (output valid, output pixel_row, output pixel_col, output pixel_out,
                  output is_extremum, output frame_done, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, input pixel_out,
                  input is_extremum, input frame_done, output ready);
endinterface

/* hdl/grid_local_extremum_detect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_extremum_detect
// Four-neighbour strict local minimum or maximum marking on a raster frame.
// ----------------------------------------------------------------------------
// Pixels enter on pix_i (valid/ready) in raster order; decisions leave on
// dec_o, one word per decided pixel, with its row, column, value, the
// extremum flag and frame_done on the last decision of the frame.
// Frame rows, frame columns and the min/max mode sit in APB registers at
// byte addresses 0, 4 and 8; any write to them restarts the frame.
// Decisions run one row behind the input: the pixel at (i,j) releases the
// decision for (i-1,j). In the last row it also releases (i,j-1) and, at
// the row end, (i,j).
// The first decision word of an accepted pixel is registered in the item
// and store read registers, then in the output register.
// Throughput: one pixel per cycle while dec_o takes every word; in the last
// row a pixel is held until its decision words (two, three at the row end)
// have gone through the single output register that takes one word a cycle.
// Per pixel both line stores take two reads; the store of the current row
// also takes the write.
// Reset clears counters and the pipeline; line store contents are not
// cleared. When dec_o stalls, the output word holds and ready on pix_i
// drops once the pending decisions of the pixel in flight cannot drain.
// ----------------------------------------------------------------------------
module grid_local_extremum_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gled_pix_if.sink                      pix_i,
  gled_dec_if.source                    dec_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gled_pkg::AddrBits-1:0] paddr,
  input  logic [gled_pkg::DataBits-1:0] pwdata,
  output logic [gled_pkg::DataBits-1:0] prdata,
  output logic                          pready
);

  gled_pkg::cfg_t               cfg;
  gled_pkg::item_t              item;
  gled_pkg::rd_t                rd;
  logic                         restart, accept, dec_ready;
  logic [gled_pkg::RowBits-1:0] row_q, row_d;
  logic [gled_pkg::ColBits-1:0] col_q, col_d, col_p1;
  logic                         bank_q, bank_d;

  gled_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  assign accept      = pix_i.valid && dec_ready;
  assign pix_i.ready = dec_ready;
  assign col_p1      = col_q + gled_pkg::ColBits'(1);

  always_comb begin
    item.pixel     = pix_i.pixel_value;
    item.row       = row_q;
    item.col       = col_q;
    item.bank      = bank_q;
    item.has_up    = row_q != '0;
    item.has_up2   = row_q[gled_pkg::RowBits-1:1] != '0;
    item.has_left  = col_q != '0;
    item.has_left2 = col_q[gled_pkg::ColBits-1:1] != '0;
    item.has_right = col_q != cfg.last_col;
    item.last_row  = row_q == cfg.last_row;
    item.last_col  = col_q == cfg.last_col;
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    bank_d = bank_q;
    if (restart) begin
      row_d  = '0;
      col_d  = '0;
      bank_d = 1'b0;
    end else if (accept) begin
      if (col_q == cfg.last_col) begin
        col_d  = '0;
        bank_d = ~bank_q;
        row_d  = (row_q == cfg.last_row) ? '0 : row_q + gled_pkg::RowBits'(1);
      end else begin
        col_d = col_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      bank_q <= bank_d;
    end
  end

  gled_line_store u_store_a (
    .clk_i    (clk_i),
    .we_i     (accept && !bank_q),
    .waddr_i  (col_q),
    .wdata_i  (pix_i.pixel_value),
    .re_i     (accept),
    .raddr0_i (col_q),
    .raddr1_i (col_p1),
    .rdata0_o (rd.a0),
    .rdata1_o (rd.a1)
  );

  gled_line_store u_store_b (
    .clk_i    (clk_i),
    .we_i     (accept && bank_q),
    .waddr_i  (col_q),
    .wdata_i  (pix_i.pixel_value),
    .re_i     (accept),
    .raddr0_i (col_q),
    .raddr1_i (col_p1),
    .rdata0_o (rd.b0),
    .rdata1_o (rd.b1)
  );

  gled_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .kind_i   (cfg.kind),
    .accept_i (accept),
    .item_i   (item),
    .rd_i     (rd),
    .ready_o  (dec_ready),
    .dec_o    (dec_o)
  );

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= cfg.last_col)
    else $error("column counter beyond row length");

  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart && col_q == cfg.last_col) |=> (bank_q != $past(bank_q)))
    else $error("line stores not swapped at row end");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (row_q == '0 && col_q == '0 && !bank_q))
    else $error("frame not restarted after register write");

endmodule

/* hdl/gled_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gled_cfg_regs
// APB register file: frame size and mode, clamped geometry, restart pulse.
// ----------------------------------------------------------------------------
module gled_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gled_pkg::AddrBits-1:0] paddr,
  input  logic [gled_pkg::DataBits-1:0] pwdata,
  output logic [gled_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  output gled_pkg::cfg_t                cfg_o,
  output logic                          restart_o
);

  logic [gled_pkg::RowsRegBits-1:0] rows_q, rows_d, rows_m1;
  logic [gled_pkg::ColsRegBits-1:0] cols_q, cols_d, cols_m1;
  logic                             kind_q, kind_d;
  logic [1:0]                       idx;
  logic                             wr;

  assign pready = 1'b1;
  assign idx    = paddr[gled_pkg::AddrBits-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    rows_d    = rows_q;
    cols_d    = cols_q;
    kind_d    = kind_q;
    restart_o = wr && (idx inside {gled_pkg::RegFrameRows, gled_pkg::RegFrameCols,
                                   gled_pkg::RegExtremumKind});
    if (wr) begin
      case (idx)
        gled_pkg::RegFrameRows:    rows_d = pwdata[gled_pkg::RowsRegBits-1:0];
        gled_pkg::RegFrameCols:    cols_d = pwdata[gled_pkg::ColsRegBits-1:0];
        gled_pkg::RegExtremumKind: kind_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gled_pkg::RegFrameRows:    prdata = gled_pkg::DataBits'(rows_q);
      gled_pkg::RegFrameCols:    prdata = gled_pkg::DataBits'(cols_q);
      gled_pkg::RegExtremumKind: prdata = gled_pkg::DataBits'(kind_q);
      default:                   prdata = '0;
    endcase
  end

  // zero acts as one, oversize as the maximum
  assign rows_m1 = rows_q - gled_pkg::RowsRegBits'(1);
  assign cols_m1 = cols_q - gled_pkg::ColsRegBits'(1);

  always_comb begin
    if (rows_q == '0) begin
      cfg_o.last_row = '0;
    end else if (rows_q >= gled_pkg::RowsRegBits'(gled_pkg::MaxRows)) begin
      cfg_o.last_row = '1;
    end else begin
      cfg_o.last_row = rows_m1[gled_pkg::RowBits-1:0];
    end
    if (cols_q == '0) begin
      cfg_o.last_col = '0;
    end else if (cols_q >= gled_pkg::ColsRegBits'(gled_pkg::LineDepth)) begin
      cfg_o.last_col = '1;
    end else begin
      cfg_o.last_col = cols_m1[gled_pkg::ColBits-1:0];
    end
    cfg_o.kind = kind_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gled_pkg::RowsRegBits'(8);
      cols_q <= gled_pkg::ColsRegBits'(8);
      kind_q <= 1'b0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      kind_q <= kind_d;
    end
  end

endmodule

/* hdl/gled_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gled_line_store
// One row of pixels: one write port, two registered read ports, read first.
// ----------------------------------------------------------------------------
module gled_line_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [gled_pkg::ColBits-1:0] waddr_i,
  input  gled_pkg::pix_t               wdata_i,
  input  logic                         re_i,
  input  logic [gled_pkg::ColBits-1:0] raddr0_i,
  input  logic [gled_pkg::ColBits-1:0] raddr1_i,
  output gled_pkg::pix_t               rdata0_o,
  output gled_pkg::pix_t               rdata1_o
);

  gled_pkg::pix_t mem_q [gled_pkg::LineDepth];
  gled_pkg::pix_t rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd0_q <= mem_q[raddr0_i];
      rd1_q <= mem_q[raddr1_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

/* hdl/gled_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gled_decide
// Neighbour compares on the store read data, up to three decisions per
// pixel issued one a cycle into the output register while dec_o takes them.
// ----------------------------------------------------------------------------
module gled_decide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              kind_i,
  input  logic              accept_i,
  input  gled_pkg::item_t   item_i,
  input  gled_pkg::rd_t     rd_i,
  output logic              ready_o,
  gled_dec_if.source        dec_o
);

  gled_pkg::item_t s1_q;
  gled_pkg::pix_t  hist_p_q, hist2_q, hist_prv_q;
  gled_pkg::pix_t  old_w, prv_j, prv_j1;
  gled_pkg::res_t  top_r, row_r, end_r, pick, out_q, out_d;
  logic [2:0]      pend_q, pend_d, low, pend_after, pend_load;
  logic            out_valid_q, out_valid_d, push;

  always_comb begin
    old_w  = s1_q.bank ? rd_i.b0 : rd_i.a0;
    prv_j  = s1_q.bank ? rd_i.a0 : rd_i.b0;
    prv_j1 = s1_q.bank ? rd_i.a1 : rd_i.b1;

    // (i-1, j): row above the pixel just taken
    top_r.row  = s1_q.row - gled_pkg::RowBits'(1);
    top_r.col  = s1_q.col;
    top_r.pix  = prv_j;
    top_r.ext  = gled_pkg::beats(kind_i, prv_j, s1_q.pixel)
              && (!s1_q.has_up2   || gled_pkg::beats(kind_i, prv_j, old_w))
              && (!s1_q.has_left  || gled_pkg::beats(kind_i, prv_j, hist_prv_q))
              && (!s1_q.has_right || gled_pkg::beats(kind_i, prv_j, prv_j1));
    top_r.done = 1'b0;

    // (i, j-1): last row, left of the pixel just taken
    row_r.row  = s1_q.row;
    row_r.col  = s1_q.col - gled_pkg::ColBits'(1);
    row_r.pix  = hist_p_q;
    row_r.ext  = gled_pkg::beats(kind_i, hist_p_q, s1_q.pixel)
              && (!s1_q.has_up    || gled_pkg::beats(kind_i, hist_p_q, hist_prv_q))
              && (!s1_q.has_left2 || gled_pkg::beats(kind_i, hist_p_q, hist2_q));
    row_r.done = 1'b0;

    // (i, j): final pixel of the frame
    end_r.row  = s1_q.row;
    end_r.col  = s1_q.col;
    end_r.pix  = s1_q.pixel;
    end_r.ext  = (!s1_q.has_up   || gled_pkg::beats(kind_i, s1_q.pixel, prv_j))
              && (!s1_q.has_left || gled_pkg::beats(kind_i, s1_q.pixel, hist_p_q));
    end_r.done = 1'b1;
  end

  assign low        = pend_q & (~pend_q + 3'd1);
  assign pend_after = pend_q & ~low;
  assign push       = (pend_q != '0) && (!out_valid_q || dec_o.ready);
  assign ready_o    = (pend_q == '0) || (push && (pend_after == '0));
  assign pend_load  = {item_i.last_row && item_i.last_col,
                       item_i.last_row && item_i.has_left,
                       item_i.has_up};

  always_comb begin
    if (low[0]) begin
      pick = top_r;
    end else if (low[1]) begin
      pick = row_r;
    end else begin
      pick = end_r;
    end
    pend_d      = accept_i ? pend_load : (push ? pend_after : pend_q);
    out_valid_d = push ? 1'b1 : (dec_o.ready ? 1'b0 : out_valid_q);
    out_d       = push ? pick : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // history of the two previous pixels of the row, and the row above
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept_i) begin
      s1_q       <= item_i;
      hist_p_q   <= s1_q.pixel;
      hist2_q    <= hist_p_q;
      hist_prv_q <= prv_j;
    end
  end

  assign dec_o.valid       = out_valid_q;
  assign dec_o.pixel_row   = out_q.row;
  assign dec_o.pixel_col   = out_q.col;
  assign dec_o.pixel_out   = out_q.pix;
  assign dec_o.is_extremum = out_q.ext;
  assign dec_o.frame_done  = out_q.done;

endmodule
